[design/led_color_playbook_sequencer_unit_assert.svh]
// Assertion macros shared by the sequencer RTL.
`ifndef LED_COLOR_PLAYBOOK_SEQUENCER_UNIT_ASSERT_SVH
`define LED_COLOR_PLAYBOOK_SEQUENCER_UNIT_ASSERT_SVH

// Checked on every rising clock edge, suspended while reset is asserted.
`define LCPS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, also during reset.
`define LCPS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/lcps_pkg.sv]
package lcps_pkg;

	localparam int unsigned LCPS_TABLE_DEPTH = 16;
	localparam int unsigned IDX_W = 4;
	localparam int unsigned POS_W = 5;
	localparam int unsigned TICK_W = 16;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_LENGTH = 2'd2;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [TICK_W-1:0] ticks;
	} entry_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] idx;
		entry_t data;
	} tbl_wr_t;

endpackage

[design/lcps_table.sv]
module lcps_table #(
	parameter int unsigned TABLE_DEPTH = lcps_pkg::LCPS_TABLE_DEPTH
) (
	input logic clk,
	input lcps_pkg::tbl_wr_t wr,
	input logic [lcps_pkg::POS_W-1:0] rd_pos,
	output lcps_pkg::entry_t rd_entry
);
	import lcps_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned XW = (AW > POS_W) ? AW : POS_W;

	entry_t mem [TABLE_DEPTH];
	entry_t rd_q;

	logic [XW-1:0] wr_ext;
	logic [XW-1:0] rd_ext;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic hit;

	assign wr_ext = XW'(wr.idx);
	assign rd_ext = XW'(rd_pos);
	assign wr_addr = wr_ext[AW-1:0];
	assign rd_addr = rd_ext[AW-1:0];
	assign hit = wr.en && (POS_W'(wr.idx) == rd_pos);

	// The read port always follows the next play position, so the registered
	// output holds the current entry; a write to that entry is forwarded.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
		if (hit) begin
			rd_q <= wr.data;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_entry = rd_q;

endmodule

[design/led_color_playbook_sequencer_unit.sv]
// LED color playbook sequencer.
// Items arrive on the s_ stream: s_tuser carries the mode (frame tick, table
// write, or length load) and s_tdata the entry and length fields. A frame tick
// produces one transfer on the m_ stream with the color of the playing entry,
// its index and a lit flag; table writes and length loads produce nothing.
// An accepted item is registered in the input stage, processed from there, and
// a tick's result is registered in the result register that drives m_tvalid.
// One item is accepted every cycle while no tick is stalled; the table read
// port runs one step ahead of the play position, keeping each tick's entry ready.
// Reset empties the playbook (the LED stays dark) and clears the position and
// tick count; table contents are unknown until written.
// When the receiver holds m_tready low, the result register keeps its value,
// ticks stop behind it, and s_tready drops once the input stage is full.
// Writes and length loads still pass through the input stage during a stall.
module led_color_playbook_sequencer_unit #(
	parameter int unsigned TABLE_DEPTH = lcps_pkg::LCPS_TABLE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// From bit 0: entry_index[3:0], entry_red[11:4], entry_green[19:12],
	// entry_blue[27:20], entry_ticks[43:28], new_length[48:44], zero fill.
	input logic [55:0] s_tdata,
	// From bit 0: mode[1:0].
	input logic [1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// From bit 0: led_red[7:0], led_green[15:8], led_blue[23:16],
	// shown_entry[27:24], led_lit[28], zero fill.
	output logic [31:0] m_tdata
);
	import lcps_pkg::*;

	localparam int unsigned CNT_MAX = (TABLE_DEPTH > 31) ? 31 : TABLE_DEPTH;
	localparam logic [8:0] DEPTH_V = 9'(TABLE_DEPTH);

	logic valid_s1;
	logic [1:0] mode_s1;
	logic [IDX_W-1:0] idx_s1;
	entry_t entry_s1;
	logic [POS_W-1:0] len_s1;

	logic [POS_W-1:0] count_q;
	logic [POS_W-1:0] pos_q;
	logic [TICK_W-1:0] held_q;
	logic out_valid_q;
	logic [28:0] out_data_q;

	logic s1_adv;
	logic fire;
	logic empty;
	entry_t cur;
	logic [TICK_W:0] hold_eff;
	logic [TICK_W:0] held_inc;
	logic [POS_W-1:0] pos_inc;
	logic [POS_W-1:0] pos_wrap;
	logic [POS_W-1:0] len_sat;
	logic [POS_W-1:0] count_n;
	logic [POS_W-1:0] pos_n;
	logic [TICK_W-1:0] held_n;
	logic [28:0] result;
	tbl_wr_t wr;

	assign s1_adv = (mode_s1 != MODE_TICK) || !out_valid_q || m_tready;
	assign fire = valid_s1 && s1_adv;
	assign s_tready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser;
			idx_s1 <= s_tdata[3:0];
			entry_s1.red <= s_tdata[11:4];
			entry_s1.green <= s_tdata[19:12];
			entry_s1.blue <= s_tdata[27:20];
			entry_s1.ticks <= s_tdata[43:28];
			len_s1 <= s_tdata[48:44];
		end
	end

	assign wr.en = fire && (mode_s1 == MODE_WRITE) && (9'(idx_s1) < DEPTH_V);
	assign wr.idx = idx_s1;
	assign wr.data = entry_s1;

	lcps_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk(clk),
		.wr(wr),
		.rd_pos(pos_n),
		.rd_entry(cur)
	);

	assign empty = (count_q == '0) || (pos_q >= count_q);
	assign hold_eff = (cur.ticks == '0) ? (TICK_W+1)'(1) : {1'b0, cur.ticks};
	assign held_inc = {1'b0, held_q} + (TICK_W+1)'(1);
	assign pos_inc = pos_q + POS_W'(1);
	assign pos_wrap = (pos_inc >= count_q) ? '0 : pos_inc;
	assign len_sat = (len_s1 > POS_W'(CNT_MAX)) ? POS_W'(CNT_MAX) : len_s1;

	always_comb begin
		count_n = count_q;
		pos_n = pos_q;
		held_n = held_q;
		if (fire) begin
			case (mode_s1)
				MODE_LENGTH: begin
					count_n = len_sat;
					pos_n = '0;
					held_n = '0;
				end
				MODE_TICK: begin
					if (!empty) begin
						if (held_inc >= hold_eff) begin
							held_n = '0;
							pos_n = pos_wrap;
						end else begin
							held_n = held_inc[TICK_W-1:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (empty) begin
			result = '0;
		end else begin
			result = {(|{cur.red, cur.green, cur.blue}), pos_q[IDX_W-1:0],
				cur.blue, cur.green, cur.red};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q <= '0;
			held_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_n;
			pos_q <= pos_n;
			held_q <= held_n;
			if (fire && (mode_s1 == MODE_TICK)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (mode_s1 == MODE_TICK)) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'b000, out_data_q};

`include "led_color_playbook_sequencer_unit_assert.svh"

	`LCPS_ASSERT(a_pos_in_range, (count_q == '0) || (pos_q < count_q), "play position beyond length")
	`LCPS_ASSERT(a_length_restart, fire && (mode_s1 == MODE_LENGTH) |=> (pos_q == '0) && (held_q == '0), "length load did not restart play")
	`LCPS_ASSERT(a_empty_dark, fire && (mode_s1 == MODE_TICK) && (count_q == '0) |=> m_tvalid && (m_tdata == '0), "empty playbook produced light")
	`LCPS_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_tvalid && (count_q == '0), "sequencer active during reset")

endmodule
